FILE: rtl/core/vkvt_pkg.sv
// Shared types, constants and string helpers for the variable key/value table.
// No dependencies; used by the top level core.
`timescale 1ns / 1ps
`default_nettype none

package vkvt_pkg;

    // Default number of table slots.
    localparam int SLOT_COUNT_DEF = 64;
    // Only this many low bytes of a name or value are significant.
    localparam int NAME_BYTES = 8;
    localparam int WORD_W = 64;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_GET   = 2'd1;
    localparam t_cmd CMD_SET   = 2'd2;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;

    // Keep the significant low bytes, ending the string at its first zero byte.
    function automatic logic [WORD_W-1:0] normalize(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        logic              alive;
        r     = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (alive && (i < NAME_BYTES) && (v[8*i +: 8] != 8'h00)) begin
                r[8*i +: 8] = v[8*i +: 8];
            end else begin
                alive = 1'b0;
            end
        end
        return r;
    endfunction

    // Remove one trailing type symbol from a normalized string.
    function automatic logic [WORD_W-1:0] strip_symbol(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        logic [7:0]        nz;
        r = v;
        for (int i = 0; i < 8; i++) begin
            nz[i] = (v[8*i +: 8] != 8'h00);
        end
        for (int i = 0; i < 7; i++) begin
            if (nz[i] && !nz[i+1] &&
                (v[8*i +: 8] == CHAR_PERCENT || v[8*i +: 8] == CHAR_DOLLAR)) begin
                r[8*i +: 8] = 8'h00;
            end
        end
        if (nz[7] && (v[63:56] == CHAR_PERCENT || v[63:56] == CHAR_DOLLAR)) begin
            r[63:56] = 8'h00;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vkvt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; instantiated by the table core for names and values.
`timescale 1ns / 1ps
`default_nettype none

module vkvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/variable_key_value_table_core.sv
// Top level of the variable key/value table: command sequencer, fill counter and slot scan.
// Depends on vkvt_pkg and vkvt_ram.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low. Clear requests and the
// unused command code finish at once: their result is registered, appears in the
// next cycle, and busy never rises. A get or set scans the occupied slots in order
// through the name memory's read port, one slot per cycle, and stops at the first
// match. A get that matches then reads the value memory before giving its result.
// Occupied slots always form a prefix of the table, so a fill count stands in for
// per-slot valid bits and a clear only resets the fill count.
// Each result is shown for exactly one cycle with o_valid high; the receiver
// cannot stall it, and a new request may be accepted in that same cycle.
module variable_key_value_table_core #(
    parameter int SLOT_COUNT = vkvt_pkg::SLOT_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [63:0] i_var_name,
    input  wire logic [63:0] i_new_value,
    output logic             o_valid,
    output logic [63:0]      o_read_value,
    output logic             o_status,
    output logic             o_found_existing
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_VOUT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_chk, n_chk;
    logic          r_pend, n_pend;
    vkvt_pkg::t_cmd r_cmd, n_cmd;
    logic [63:0]   r_name, n_name;
    logic [63:0]   r_value, n_value;

    logic          r_valid, n_valid;
    logic [63:0]   r_rv, n_rv;
    logic          r_status, n_status;
    logic          r_found, n_found;

    logic          name_we, value_we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] value_raddr;
    logic [63:0]   name_rdata, value_rdata;
    logic          name_hit;

    assign name_hit = r_pend && (name_rdata == r_name);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_addr      = r_addr;
        n_chk       = r_chk;
        n_pend      = r_pend;
        n_cmd       = r_cmd;
        n_name      = r_name;
        n_value     = r_value;
        n_valid     = 1'b0;
        n_rv        = r_rv;
        n_status    = r_status;
        n_found     = r_found;
        name_we     = 1'b0;
        value_we    = 1'b0;
        waddr       = r_chk[AW-1:0];
        value_raddr = r_chk[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_name  = vkvt_pkg::strip_symbol(vkvt_pkg::normalize(i_var_name));
                    n_value = vkvt_pkg::normalize(i_new_value);
                    n_cmd   = i_cmd;
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    if (i_cmd == vkvt_pkg::CMD_GET || i_cmd == vkvt_pkg::CMD_SET) begin
                        n_state = S_SCAN;
                    end else begin
                        // Clear and the unused code answer with all-zero fields.
                        if (i_cmd == vkvt_pkg::CMD_CLEAR) begin
                            n_fill = '0;
                        end
                        n_valid  = 1'b1;
                        n_rv     = '0;
                        n_status = 1'b0;
                        n_found  = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                if (name_hit) begin
                    n_pend  = 1'b0;
                    n_found = 1'b1;
                    n_status = 1'b0;
                    if (r_cmd == vkvt_pkg::CMD_GET) begin
                        // Fetch the value; it is ready in the next cycle.
                        n_state = S_VOUT;
                    end else begin
                        value_we = 1'b1;
                        n_rv     = r_value;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (r_addr == r_fill) begin
                    // No occupied slot matched: the first empty slot is at the fill count.
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    waddr   = r_fill[AW-1:0];
                    if (r_fill == SLOTS) begin
                        n_status = 1'b1;
                        n_rv     = '0;
                    end else begin
                        n_status = 1'b0;
                        if (r_cmd == vkvt_pkg::CMD_GET) begin
                            n_rv = '0;
                        end else begin
                            n_rv = r_value;
                            if (r_name != '0) begin
                                name_we  = 1'b1;
                                value_we = 1'b1;
                                n_fill   = r_fill + CW'(1);
                            end
                        end
                    end
                end else begin
                    n_pend = 1'b1;
                    n_chk  = r_addr;
                    n_addr = r_addr + CW'(1);
                end
            end
            S_VOUT: begin
                n_rv     = value_rdata;
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_addr   <= n_addr;
        r_chk    <= n_chk;
        r_cmd    <= n_cmd;
        r_name   <= n_name;
        r_value  <= n_value;
        r_rv     <= n_rv;
        r_status <= n_status;
        r_found  <= n_found;
    end

    vkvt_ram #(
        .WIDTH(vkvt_pkg::WORD_W),
        .DEPTH(SLOT_COUNT)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (waddr),
        .i_wdata (r_name),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (name_rdata)
    );

    vkvt_ram #(
        .WIDTH(vkvt_pkg::WORD_W),
        .DEPTH(SLOT_COUNT)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (value_we),
        .i_waddr (waddr),
        .i_wdata (r_value),
        .i_raddr (value_raddr),
        .o_rdata (value_rdata)
    );

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_read_value     = r_rv;
    assign o_status         = r_status;
    assign o_found_existing = r_found;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SLOTS)
        else $error("fill count exceeds the slot count");

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_chk < r_fill))
        else $error("scan checks a slot beyond the occupied range");

    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (!o_found_existing && o_read_value == '0))
        else $error("full result carries a match or a value");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == vkvt_pkg::CMD_GET || i_cmd == vkvt_pkg::CMD_SET))
        |=> (busy && !o_valid))
        else $error("get or set request did not start a scan");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == vkvt_pkg::CMD_CLEAR) |=> (r_fill == '0 && o_valid))
        else $error("clear request did not empty the table");

endmodule

`default_nettype wire
